>>> design/ipa_pkg.sv
// ============================================================================
// ipa_pkg
// Shared constants and types of the identifier pool allocator.
// ============================================================================
`default_nettype none

package ipa_pkg;

   // Identifier width that the pool is built for unless told otherwise.
   localparam int ID_BITS_DEF = 8;

   // Widest identifier the internal map interface can carry.
   localparam int ID_FIELD_W = 16;

   // Field widths of the channels and the registers.
   localparam int MODE_W    = 2;
   localparam int REQ_ID_W  = 8;
   localparam int GIVEN_W   = 8;
   localparam int STATUS_W  = 3;
   localparam int CFG_W     = 8;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // Bitmap word width and its index width.
   localparam int WORD_BITS = 16;
   localparam int WORD_LW   = 4;

   // Request modes.
   localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd2;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_REUSED   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FRESH    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_DOUBLE   = 3'd4;
   localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd5;

   // Register select, taken from address bit 2.
   localparam logic REG_MAX_ID   = 1'b0;
   localparam logic REG_RESERVED = 1'b1;

   // Command from the sequencer to the free map.
   typedef struct packed {
      logic                  alloc;
      logic                  release_id;
      logic                  clear;
      logic [ID_FIELD_W-1:0] id;
   } map_cmd_type;

   // Answer of the free map.
   typedef struct packed {
      logic                  busy;
      logic                  done;
      logic                  found;
      logic                  dbl;
      logic [ID_FIELD_W-1:0] id;
   } map_rsp_type;

endpackage

`default_nettype wire

>>> design/ipa_req_if.sv
// ============================================================================
// ipa_req_if
// Request channel: mode and identifier, with a valid/ready handshake.
// ============================================================================
`default_nettype none

interface ipa_req_if;
   import ipa_pkg::*;

   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic [REQ_ID_W-1:0] request_id;

   modport source (output valid, output mode, output request_id, input ready);
   modport sink   (input valid, input mode, input request_id, output ready);
endinterface

`default_nettype wire

>>> design/ipa_rsp_if.sv
// ============================================================================
// ipa_rsp_if
// Result channel: identifier handed out and status, with a valid/ready handshake.
// ============================================================================
`default_nettype none

interface ipa_rsp_if;
   import ipa_pkg::*;

   logic                valid;
   logic                ready;
   logic [GIVEN_W-1:0]  given_id;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output given_id, output status, input ready);
   modport sink   (input valid, input given_id, input status, output ready);
endinterface

`default_nettype wire

>>> design/ipa_free_map.sv
// ============================================================================
// ipa_free_map
// Two-level bitmap of released identifiers held in two synchronous memories,
// with a flop vector of summary-word flags on top.
// ============================================================================
`default_nettype none

module ipa_free_map #(
   parameter int ID_BITS = ipa_pkg::ID_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ipa_pkg::map_cmd_type cmd,
   output ipa_pkg::map_rsp_type      rsp
);
   import ipa_pkg::*;

   // The map is padded to at least nine identifier bits so every level exists.
   localparam int XB  = (ID_BITS > 9) ? ID_BITS : 9;
   localparam int WB  = WORD_BITS;
   localparam int LW  = WORD_LW;
   localparam int A0  = XB - LW;
   localparam int A1  = XB - 2 * LW;
   localparam int N0  = 2 ** A0;
   localparam int N1  = 2 ** A1;
   localparam int CW  = (N1 < WB) ? N1 : WB;
   localparam int NC  = N1 / CW;
   localparam int CB  = (NC > 1) ? $clog2(NC) : 1;
   localparam int CWB = $clog2(CW);

   localparam logic [2:0] M_IDLE = 3'd0;
   localparam logic [2:0] M_SCAN = 3'd1;
   localparam logic [2:0] M_RD1  = 3'd2;
   localparam logic [2:0] M_RD0  = 3'd3;
   localparam logic [2:0] M_RDR  = 3'd4;

   function automatic logic [LW-1:0] ffs_word(input logic [WB-1:0] v);
      logic [LW-1:0] r;
      r = '0;
      for (int i = WB - 1; i >= 0; i--) begin
         if (v[i]) begin
            r = LW'(i);
         end
      end
      return r;
   endfunction

   logic [WB-1:0] mem0 [N0];
   logic [WB-1:0] mem1 [N1];
   logic [WB-1:0] mem0_q;
   logic [WB-1:0] mem1_q;

   logic          rd0_en, rd1_en, wr0_en, wr1_en;
   logic [A0-1:0] rd0_addr, wr0_addr;
   logic [A1-1:0] rd1_addr, wr1_addr;
   logic [WB-1:0] wr0_data, wr1_data;

   logic [2:0]    state_ff, state_in;
   logic [N1-1:0] top_ff, top_in;
   logic [CB-1:0] chunk_ff, chunk_in;
   logic [A1-1:0] tidx_ff, tidx_in;
   logic [WB-1:0] word1_ff, word1_in;
   logic [LW-1:0] f1_ff, f1_in;
   logic [XB-1:0] id_ff, id_in;
   logic          done_ff, done_in;
   logic          found_ff, found_in;
   logic          dbl_ff, dbl_in;
   logic [XB-1:0] res_id_ff, res_id_in;

   logic [CW-1:0] chunk_bits;
   logic [A1-1:0] tsel;
   logic [LW-1:0] f1_now, f0_now;
   logic [WB-1:0] w0_new, w1_new, w0_rel, w1_rel;
   logic [XB-1:0] cmd_id;

   if (NC == 1) begin : g_one_chunk
      assign chunk_bits = top_ff;
   end else begin : g_many_chunks
      logic [NC-1:0][CW-1:0] top_view;
      assign top_view   = top_ff;
      assign chunk_bits = top_view[chunk_ff];
   end

   assign cmd_id = XB'(cmd.id);
   assign tsel   = A1'({chunk_ff, CWB'(ffs_word(WB'(chunk_bits)))});
   assign f1_now = ffs_word(mem1_q);
   assign f0_now = ffs_word(mem0_q);
   assign w0_new = mem0_q & ~(WB'(1) << f0_now);
   assign w1_new = word1_ff & ~(WB'(1) << f1_ff);

   // A word under a clear summary bit is stale and reads as empty.
   assign w1_rel = top_ff[id_ff[XB-1:2*LW]] ? mem1_q : '0;
   assign w0_rel = w1_rel[id_ff[2*LW-1:LW]] ? mem0_q : '0;

   always_comb begin
      state_in  = state_ff;
      top_in    = top_ff;
      chunk_in  = chunk_ff;
      tidx_in   = tidx_ff;
      word1_in  = word1_ff;
      f1_in     = f1_ff;
      id_in     = id_ff;
      done_in   = 1'b0;
      found_in  = found_ff;
      dbl_in    = dbl_ff;
      res_id_in = res_id_ff;
      rd0_en    = 1'b0;
      rd1_en    = 1'b0;
      wr0_en    = 1'b0;
      wr1_en    = 1'b0;
      rd0_addr  = id_ff[XB-1:LW];
      rd1_addr  = id_ff[XB-1:2*LW];
      wr0_addr  = id_ff[XB-1:LW];
      wr1_addr  = id_ff[XB-1:2*LW];
      wr0_data  = w0_rel | (WB'(1) << id_ff[LW-1:0]);
      wr1_data  = w1_rel | (WB'(1) << id_ff[2*LW-1:LW]);
      unique case (state_ff)
         M_IDLE: begin
            if (cmd.clear) begin
               top_in = '0;
            end
            if (cmd.alloc) begin
               chunk_in = '0;
               state_in = M_SCAN;
            end else if (cmd.release_id) begin
               id_in    = cmd_id;
               rd0_en   = 1'b1;
               rd1_en   = 1'b1;
               rd0_addr = cmd_id[XB-1:LW];
               rd1_addr = cmd_id[XB-1:2*LW];
               state_in = M_RDR;
            end
         end
         M_SCAN: begin
            if (chunk_bits != '0) begin
               tidx_in  = tsel;
               rd1_en   = 1'b1;
               rd1_addr = tsel;
               state_in = M_RD1;
            end else if (chunk_ff == CB'(NC - 1)) begin
               done_in  = 1'b1;
               found_in = 1'b0;
               state_in = M_IDLE;
            end else begin
               chunk_in = chunk_ff + 1'b1;
            end
         end
         M_RD1: begin
            word1_in = mem1_q;
            f1_in    = f1_now;
            rd0_en   = 1'b1;
            rd0_addr = {tidx_ff, f1_now};
            state_in = M_RD0;
         end
         M_RD0: begin
            wr0_en   = 1'b1;
            wr0_addr = {tidx_ff, f1_ff};
            wr0_data = w0_new;
            if (w0_new == '0) begin
               wr1_en   = 1'b1;
               wr1_addr = tidx_ff;
               wr1_data = w1_new;
               if (w1_new == '0) begin
                  top_in[tidx_ff] = 1'b0;
               end
            end
            done_in   = 1'b1;
            found_in  = 1'b1;
            res_id_in = {tidx_ff, f1_ff, f0_now};
            state_in  = M_IDLE;
         end
         M_RDR: begin
            if (w0_rel[id_ff[LW-1:0]]) begin
               dbl_in = 1'b1;
            end else begin
               dbl_in = 1'b0;
               wr0_en = 1'b1;
               wr1_en = 1'b1;
               top_in[id_ff[XB-1:2*LW]] = 1'b1;
            end
            done_in  = 1'b1;
            state_in = M_IDLE;
         end
         default: begin
            state_in = M_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         top_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         top_ff   <= top_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      chunk_ff  <= chunk_in;
      tidx_ff   <= tidx_in;
      word1_ff  <= word1_in;
      f1_ff     <= f1_in;
      id_ff     <= id_in;
      found_ff  <= found_in;
      dbl_ff    <= dbl_in;
      res_id_ff <= res_id_in;
   end

   always_ff @(posedge clock) begin
      if (wr0_en) begin
         mem0[wr0_addr] <= wr0_data;
      end
      if (rd0_en) begin
         mem0_q <= mem0[rd0_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr1_en) begin
         mem1[wr1_addr] <= wr1_data;
      end
      if (rd1_en) begin
         mem1_q <= mem1[rd1_addr];
      end
   end

   assign rsp.busy  = (state_ff != M_IDLE);
   assign rsp.done  = done_ff;
   assign rsp.found = found_ff;
   assign rsp.dbl   = dbl_ff;
   assign rsp.id    = ID_FIELD_W'(res_id_ff);

   // A summary word is only fetched under a set top flag.
   a_rd1_top_set: assert property (@(posedge clock) disable iff (reset)
      state_ff == M_RD1 |-> top_ff[tidx_ff])
      else $error("summary word fetched under a clear top flag");

   // The chosen summary bit must be set in the fetched summary word.
   a_rd0_word1_bit: assert property (@(posedge clock) disable iff (reset)
      state_ff == M_RD0 |-> word1_ff[f1_ff])
      else $error("chosen summary bit is clear");

   // A bitmap word under a set summary bit is never empty.
   a_rd0_word_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == M_RD0 |-> mem0_q != '0)
      else $error("bitmap word under a set summary bit is empty");

   // A clear empties the whole map by the next cycle.
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (state_ff == M_IDLE && cmd.clear) |=> top_ff == '0)
      else $error("clear left marks in the map");

endmodule

`default_nettype wire

>>> design/id_pool_allocator_top.sv
// ============================================================================
// id_pool_allocator_top
// Hands out and takes back identifiers from a pool of released identifiers
// and a counter that issues fresh ones.
// ============================================================================
// Usage:
//   Each request transaction (mode 0 allocate, mode 1 release request_id,
//   mode 2 clear the pool) yields exactly one result transaction with the
//   identifier handed out (zero when none) and a status code. max_id sits at
//   APB address 0 and reserved_id at address 4; write them only while idle.
// Operation:
//   The block works on one request at a time; the result is valid once it
//   fills the output register, when ready is back high. A clear, a mode-3
//   request or a release of the reserved identifier sets its status in the
//   accept cycle, and the result then fills the output register. A release
//   starts the summary and bitmap memory reads in the accept cycle; then the
//   free map tests and writes back, returns the answer to the sequencer, and
//   the result fills the output register. An allocate scans the chunks of up
//   to 16 flags of the top flag vector up to the set one (one chunk for
//   ID_BITS up to 12, up to 16 at ID_BITS = 16) before the memory reads;
//   an allocate that finds nothing scans every chunk.
// Reset and stalls:
//   Reset empties the pool by clearing the top flag vector, so no memory
//   sweep is needed; the counter returns to zero and both registers to
//   255. A stalled result is held in the output register; the next request
//   may already be accepted and finished, and waits in turn.
// ============================================================================
`default_nettype none

module id_pool_allocator_top #(
   parameter int ID_BITS = ipa_pkg::ID_BITS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   ipa_req_if.sink                               req_ch,
   ipa_rsp_if.source                             rsp_ch,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [ipa_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [ipa_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic      [ipa_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                                  pready
);
   import ipa_pkg::*;

   // Sequencer states.
   localparam logic [1:0] T_IDLE = 2'd0;
   localparam logic [1:0] T_MAP  = 2'd1;
   localparam logic [1:0] T_FIN  = 2'd2;

   localparam int CMP_W = (ID_BITS + 1 > CFG_W) ? ID_BITS + 1 : CFG_W;

   logic [1:0]          state_ff, state_in;
   logic [CFG_W-1:0]    max_id_ff, max_id_in;
   logic [CFG_W-1:0]    reserved_ff, reserved_in;
   logic [ID_BITS-1:0]  counter_ff, counter_in;
   logic                is_alloc_ff, is_alloc_in;
   logic [ID_BITS-1:0]  res_id_ff, res_id_in;
   logic [STATUS_W-1:0] res_st_ff, res_st_in;
   logic                out_valid_ff, out_valid_in;
   logic [GIVEN_W-1:0]  out_id_ff, out_id_in;
   logic [STATUS_W-1:0] out_st_ff, out_st_in;

   logic                req_fire;
   logic                csr_write;
   logic [ID_BITS-1:0]  req_id;
   logic [ID_BITS:0]    count_step;
   logic [ID_BITS-1:0]  count_next;
   map_cmd_type         map_cmd;
   map_rsp_type         map_rsp;

   ipa_free_map #(
      .ID_BITS (ID_BITS)
   ) u_free_map (
      .clock (clock),
      .reset (reset),
      .cmd   (map_cmd),
      .rsp   (map_rsp)
   );

   // Identifiers are taken in their low ID_BITS bits.
   assign req_id   = ID_BITS'(req_ch.request_id);
   assign req_fire = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == T_IDLE);

   // The counter steps to zero past max_id or past the identifier width.
   assign count_step = {1'b0, counter_ff} + 1'b1;
   assign count_next = (count_step[ID_BITS] ||
                        CMP_W'(count_step) > CMP_W'(max_id_ff)) ? '0
                       : count_step[ID_BITS-1:0];

   // Register port: writes land on the access phase; reads need no wait.
   assign csr_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == REG_RESERVED) ? CSR_DATA_W'(reserved_ff)
                                                 : CSR_DATA_W'(max_id_ff);

   always_comb begin
      max_id_in   = max_id_ff;
      reserved_in = reserved_ff;
      if (csr_write) begin
         unique case (paddr[2])
            REG_MAX_ID:   max_id_in   = pwdata[CFG_W-1:0];
            REG_RESERVED: reserved_in = pwdata[CFG_W-1:0];
            default:      max_id_in   = max_id_ff;
         endcase
      end
   end

   // Sequencer: dispatch to the free map, finish the result, hand it over.
   always_comb begin
      state_in     = state_ff;
      counter_in   = counter_ff;
      is_alloc_in  = is_alloc_ff;
      res_id_in    = res_id_ff;
      res_st_in    = res_st_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      out_id_in    = out_id_ff;
      out_st_in    = out_st_ff;
      map_cmd      = '0;
      map_cmd.id   = ID_FIELD_W'(req_id);

      unique case (state_ff)
         T_IDLE: begin
            if (req_fire) begin
               res_id_in   = '0;
               is_alloc_in = (req_ch.mode == MODE_ALLOC);
               priority if (req_ch.mode == MODE_ALLOC) begin
                  map_cmd.alloc = 1'b1;
                  state_in      = T_MAP;
               end else if (req_ch.mode == MODE_RELEASE) begin
                  // The reserved identifier is checked before the bitmap.
                  if (req_id == ID_BITS'(reserved_ff)) begin
                     res_st_in = ST_REJECTED;
                     state_in  = T_FIN;
                  end else begin
                     map_cmd.release_id = 1'b1;
                     state_in           = T_MAP;
                  end
               end else if (req_ch.mode == MODE_CLEAR) begin
                  map_cmd.clear = 1'b1;
                  counter_in    = '0;
                  res_st_in     = ST_CLEARED;
                  state_in      = T_FIN;
               end else begin
                  // The unused mode changes nothing and is rejected.
                  res_st_in = ST_REJECTED;
                  state_in  = T_FIN;
               end
            end
         end
         T_MAP: begin
            if (map_rsp.done) begin
               state_in = T_FIN;
               if (is_alloc_ff) begin
                  if (map_rsp.found) begin
                     res_id_in = ID_BITS'(map_rsp.id);
                     res_st_in = ST_REUSED;
                  end else begin
                     // No released identifier: issue a fresh one.
                     counter_in = count_next;
                     res_id_in  = count_next;
                     res_st_in  = ST_FRESH;
                  end
               end else begin
                  res_st_in = map_rsp.dbl ? ST_DOUBLE : ST_RELEASED;
               end
            end
         end
         T_FIN: begin
            // The result moves to the output register once it is free.
            if (!out_valid_ff || rsp_ch.ready) begin
               out_valid_in = 1'b1;
               out_id_in    = GIVEN_W'(res_id_ff);
               out_st_in    = res_st_ff;
               state_in     = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         max_id_ff    <= '1;
         reserved_ff  <= '1;
         counter_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         max_id_ff    <= max_id_in;
         reserved_ff  <= reserved_in;
         counter_ff   <= counter_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      is_alloc_ff <= is_alloc_in;
      res_id_ff   <= res_id_in;
      res_st_ff   <= res_st_in;
      out_id_ff   <= out_id_in;
      out_st_ff   <= out_st_in;
   end

   assign rsp_ch.valid    = out_valid_ff;
   assign rsp_ch.given_id = out_id_ff;
   assign rsp_ch.status   = out_st_ff;

   // The free map finishes only while the sequencer waits for it.
   a_done_in_map: assert property (@(posedge clock) disable iff (reset)
      map_rsp.done |-> state_ff == T_MAP)
      else $error("free map answered outside a map operation");

   // A request is only dispatched while the free map is idle.
   a_map_idle: assert property (@(posedge clock) disable iff (reset)
      (map_cmd.alloc || map_cmd.release_id) |-> !map_rsp.busy)
      else $error("request dispatched to a busy free map");

   // A clear zeroes the counter.
   a_clear_counter: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_ch.mode == MODE_CLEAR) |=> counter_ff == '0)
      else $error("clear left the counter running");

endmodule

`default_nettype wire

>>> sim/tb_id_pool_allocator_top.sv
// ============================================================================
// tb_id_pool_allocator_top
// Self-checking bench for the identifier pool allocator. It sends allocate,
// release, clear and unused-mode requests under random valid and ready
// gaps. A cycle-free model of the pool predicts each result and a monitor
// checks it. Several max_id / reserved_id settings are programmed between
// phases, and each register write is read back.
// ============================================================================
`timescale 1ns / 1ps

module tb_id_pool_allocator_top;
   import ipa_pkg::*;

   // Pool geometry of the instance under test (default ID_BITS).
   localparam int ID_BITS   = ID_BITS_DEF;
   localparam int POOL_SIZE = 1 << ID_BITS;

   // Mode 3 has no meaning in the block; it must be answered as rejected.
   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

   // Register byte addresses: register select sits on address bit 2.
   localparam logic [CSR_ADDR_W-1:0] ADDR_MAX_ID      = {REG_MAX_ID, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_RESERVED_ID = {REG_RESERVED, 2'b00};

   // Reset values of the two registers.
   localparam logic [CFG_W-1:0] MAX_ID_RESET   = 8'd255;
   localparam logic [CFG_W-1:0] RESERVED_RESET = 8'd255;

   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [REQ_ID_W-1:0] request_id;
   } pool_request_type;

   typedef struct packed {
      logic [GIVEN_W-1:0]  given_id;
      logic [STATUS_W-1:0] status;
   } pool_answer_type;

   // Clock, reset and the configuration port.
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   ipa_req_if req_ch ();
   ipa_rsp_if rsp_ch ();

   id_pool_allocator_top u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Predicted pool state. It mirrors the block: a mark per identifier that
   // has been released and may be handed out again, the fresh-identifier
   // counter, and the two registers as last written.
   // -------------------------------------------------------------------------
   logic [POOL_SIZE-1:0] released_marks = '0;
   logic [ID_BITS-1:0]   issue_count    = '0;
   logic [CFG_W-1:0]     max_id_cfg     = MAX_ID_RESET;
   logic [CFG_W-1:0]     reserved_cfg   = RESERVED_RESET;

   pool_request_type queued_requests[$];   // built by the stimulus, not yet sent
   pool_answer_type  pending_answers[$];   // predicted, not yet seen on rsp_ch

   int failures = 0;

   // Tallies for the closing summary.
   int n_reused = 0, n_fresh = 0, n_released = 0, n_double = 0;
   int n_rejected = 0, n_cleared = 0, n_settings = 1;

   // Handshake flags, set at the rising edge and used at the next falling
   // edge by the driver and the ready generator.
   logic req_taken = 1'b0;
   logic rsp_taken = 1'b0;

   // Idle bookkeeping for both sides. A "steady" side runs without gaps
   // until a coin flip ends the stretch.
   int  req_gap    = 0;
   bit  req_steady = 1'b0;
   int  rsp_stall  = 0;
   bit  rsp_steady = 1'b0;

   // Works out the answer to one request and advances the predicted state.
   function automatic pool_answer_type predict_pool_answer(input pool_request_type rq);
      pool_answer_type    ans;
      int                 slot;
      logic [ID_BITS:0]   bumped;
      logic [ID_BITS-1:0] id;

      ans.given_id = '0;
      ans.status   = ST_REJECTED;
      slot         = -1;
      id           = rq.request_id[ID_BITS-1:0];
      case (rq.mode)
         MODE_ALLOC: begin
            // The smallest released identifier wins; the counter only runs
            // when nothing is marked.
            for (int i = 0; i < POOL_SIZE; i++) begin
               if (slot < 0 && released_marks[i]) slot = i;
            end
            if (slot >= 0) begin
               released_marks[slot] = 1'b0;
               ans.given_id = GIVEN_W'(slot);
               ans.status   = ST_REUSED;
               n_reused++;
            end else begin
               // Counter wrap: past max_id or past the identifier width it
               // falls back to zero.
               bumped = {1'b0, issue_count} + 1'b1;
               if (bumped > max_id_cfg || bumped > POOL_SIZE - 1) bumped = '0;
               issue_count  = bumped[ID_BITS-1:0];
               ans.given_id = GIVEN_W'(issue_count);
               ans.status   = ST_FRESH;
               n_fresh++;
            end
         end
         MODE_RELEASE: begin
            // The reserved check comes before the double-release check.
            if (id == reserved_cfg[ID_BITS-1:0]) begin
               ans.status = ST_REJECTED;
               n_rejected++;
            end else if (released_marks[id]) begin
               ans.status = ST_DOUBLE;
               n_double++;
            end else begin
               released_marks[id] = 1'b1;
               ans.status = ST_RELEASED;
               n_released++;
            end
         end
         MODE_CLEAR: begin
            released_marks = '0;
            issue_count    = '0;
            ans.status     = ST_CLEARED;
            n_cleared++;
         end
         default: begin
            // Unused mode: nothing changes and the request is rejected.
            ans.status = ST_REJECTED;
            n_rejected++;
         end
      endcase
      return ans;
   endfunction

   // -------------------------------------------------------------------------
   // Request driver. Inputs change on the falling edge. A request stays up
   // until it is taken; after that the side waits the gap drawn for it.
   // -------------------------------------------------------------------------
   always @(negedge clock) begin : request_driver
      pool_request_type rq;
      if (reset) begin
         req_ch.valid      <= 1'b0;
         req_ch.mode       <= MODE_ALLOC;
         req_ch.request_id <= '0;
      end else if (req_ch.valid && !req_taken) begin
         // Held until the block takes it.
      end else if (req_gap != 0) begin
         req_ch.valid <= 1'b0;
         req_gap--;
      end else if (queued_requests.size() != 0) begin
         rq = queued_requests.pop_front();
         req_ch.valid      <= 1'b1;
         req_ch.mode       <= rq.mode;
         req_ch.request_id <= rq.request_id;
         if ($urandom_range(0, 39) == 0) req_steady = !req_steady;
         req_gap = req_steady ? 0 : $urandom_range(0, 10);
      end else begin
         req_ch.valid <= 1'b0;
      end
   end

   // Every accepted request is predicted at the edge that takes it.
   always @(posedge clock) begin : request_sampler
      pool_request_type rq;
      req_taken <= !reset && req_ch.valid && req_ch.ready;
      if (!reset && req_ch.valid && req_ch.ready) begin
         rq.mode       = req_ch.mode;
         rq.request_id = req_ch.request_id;
         pending_answers.push_back(predict_pool_answer(rq));
      end
   end

   // -------------------------------------------------------------------------
   // Result side back-pressure. After each result a stall length is drawn;
   // ready stays low until it has run down, which it does only while a result waits.
   // -------------------------------------------------------------------------
   always @(negedge clock) begin : result_ready_gen
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_taken) begin
            if ($urandom_range(0, 39) == 0) rsp_steady = !rsp_steady;
            rsp_stall = rsp_steady ? 0 : $urandom_range(0, 10);
         end
         rsp_ch.ready <= (rsp_stall == 0);
         if (rsp_stall != 0 && rsp_ch.valid) rsp_stall--;
      end
   end

   // Result monitor: each transaction is checked against the oldest
   // prediction, field by field.
   always @(posedge clock) begin : result_monitor
      pool_answer_type want;
      rsp_taken <= !reset && rsp_ch.valid && rsp_ch.ready;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_answers.size() == 0) begin
            $error("result transaction with none expected: given_id %0d status %0d",
                   rsp_ch.given_id, rsp_ch.status);
            failures++;
         end else begin
            want = pending_answers.pop_front();
            if (rsp_ch.given_id !== want.given_id) begin
               $error("given_id: expected %0d, got %0d", want.given_id, rsp_ch.given_id);
               failures++;
            end
            if (rsp_ch.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
               failures++;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers.
   // -------------------------------------------------------------------------
   task automatic queue_request(input logic [MODE_W-1:0] m, input logic [REQ_ID_W-1:0] id);
      pool_request_type rq;
      rq.mode       = m;
      rq.request_id = id;
      queued_requests.push_back(rq);
   endtask

   // Random mix. Release targets lean toward the range the counter can
   // reach so that reuse and double releases are frequent; a tenth of them
   // hit the reserved identifier, six tenths stay within max_id and the rest roam the whole field.
   task automatic queue_random(input int count, input int alloc_pct, input int clear_pct);
      int                  pick;
      logic [MODE_W-1:0]   m;
      logic [REQ_ID_W-1:0] id;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < alloc_pct) m = MODE_ALLOC;
         else if (pick < alloc_pct + clear_pct) m = MODE_CLEAR;
         else if (pick < alloc_pct + clear_pct + 4) m = MODE_SPARE;
         else m = MODE_RELEASE;
         pick = $urandom_range(0, 9);
         if (m == MODE_RELEASE && pick == 0) id = reserved_cfg;
         else if (m == MODE_RELEASE && pick < 7) id = REQ_ID_W'($urandom_range(0, max_id_cfg));
         else id = REQ_ID_W'($urandom_range(0, 255));
         queue_request(m, id);
      end
   endtask

   // Waits until every request is sent and every result checked.
   task automatic wait_pool_idle();
      do @(negedge clock);
      while (queued_requests.size() != 0 || req_ch.valid || pending_answers.size() != 0);
      repeat (8) @(negedge clock);
   endtask

   // One APB write followed by a read of the same register.
   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [CFG_W-1:0] value);
      string reg_name;
      reg_name = (addr == ADDR_MAX_ID) ? "max_id" : "reserved_id";
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = addr;
      pwdata  = CSR_DATA_W'(value);
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if (addr == ADDR_MAX_ID) max_id_cfg = value;
      else reserved_cfg = value;
      @(negedge clock);
      penable = 1'b0;
      pwrite  = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== CSR_DATA_W'(value)) begin
         $error("%s readback: expected %0d, got %0d", reg_name, value, prdata);
         failures++;
      end
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
   endtask

   task automatic program_pool(input logic [CFG_W-1:0] max_v, input logic [CFG_W-1:0] rsv_v);
      wait_pool_idle();
      csr_write(ADDR_MAX_ID, max_v);
      csr_write(ADDR_RESERVED_ID, rsv_v);
      n_settings++;
   endtask

   // -------------------------------------------------------------------------
   // Test sequence.
   // -------------------------------------------------------------------------
   initial begin : stimulus
      psel              = 1'b0;
      penable           = 1'b0;
      pwrite            = 1'b0;
      paddr             = '0;
      pwdata            = '0;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset settings: max_id and reserved_id both 255. Fresh identifiers,
      // a double release, release of the reserved value, reuse in ascending
      // order, the unused mode with every request bit set, and a clear.
      queue_request(MODE_ALLOC, 8'h00);
      queue_request(MODE_ALLOC, 8'hFF);
      queue_request(MODE_ALLOC, 8'h5A);
      queue_request(MODE_RELEASE, 8'd0);
      queue_request(MODE_RELEASE, 8'd0);
      queue_request(MODE_RELEASE, 8'd2);
      queue_request(MODE_RELEASE, 8'd255);
      queue_request(MODE_RELEASE, 8'h80);
      queue_request(MODE_ALLOC, 8'h00);
      queue_request(MODE_ALLOC, 8'h00);
      queue_request(MODE_ALLOC, 8'h00);
      queue_request(MODE_ALLOC, 8'h00);
      queue_request(MODE_SPARE, 8'hFF);
      queue_request(MODE_CLEAR, 8'hA5);
      queue_request(MODE_ALLOC, 8'h00);
      queue_random(180, 50, 2);

      // Tiny counter range with zero reserved: the counter wraps and hands
      // out the reserved value itself, while a release above max_id is
      // still accepted and then reused.
      program_pool(8'd3, 8'd0);
      queue_request(MODE_CLEAR, 8'h00);
      repeat (5) queue_request(MODE_ALLOC, 8'h00);
      queue_request(MODE_RELEASE, 8'd0);
      queue_request(MODE_RELEASE, 8'd200);
      queue_request(MODE_ALLOC, 8'h00);
      queue_random(120, 50, 3);

      // max_id of zero: every fresh identifier is zero.
      program_pool(8'd0, 8'd128);
      queue_random(120, 50, 3);

      // max_id of one: the counter alternates between one and zero.
      program_pool(8'd1, 8'd255);
      queue_random(120, 50, 3);

      // Full range with allocate-heavy traffic and no clears, so the
      // counter climbs from wherever the last phase left it.
      program_pool(8'd255, 8'd0);
      queue_random(170, 65, 0);

      // A random setting to finish.
      program_pool(CFG_W'($urandom_range(1, 254)), CFG_W'($urandom_range(0, 255)));
      queue_random(116, 50, 3);

      wait_pool_idle();
      repeat (20) @(negedge clock);
      if (pending_answers.size() != 0) begin
         $error("%0d expected results never arrived", pending_answers.size());
         failures++;
      end

      $display("Checked %0d allocates (%0d reused, %0d fresh) and %0d releases",
               n_reused + n_fresh, n_reused, n_fresh, n_released + n_double);
      $display("(%0d double), %0d rejected, %0d clears over %0d register settings.",
               n_double, n_rejected, n_cleared, n_settings);
      if (failures == 0) begin
         $display("id_pool_allocator_top: match");
      end else begin
         $display("id_pool_allocator_top: mismatch");
      end
      $finish;
   end

   // Watchdog: a correct run ends well inside this time.
   initial begin : watchdog
      #2_000_000;
      $display("id_pool_allocator_top: mismatch");
      $finish;
   end

endmodule

>>> files.f
design/ipa_pkg.sv
design/ipa_req_if.sv
design/ipa_rsp_if.sv
design/ipa_free_map.sv
design/id_pool_allocator_top.sv
sim/tb_id_pool_allocator_top.sv
